// ===== hdl/assert_macros.svh =====
// assertion macros shared by the envelope generator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every rising edge outside reset
`define ASSERT_CLK(lbl, prop, clk, rst_n) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// condition must never be seen at a rising edge outside reset
`define ASSERT_NEVER(lbl, cond, clk, rst_n) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop, clk, rst_n)
`define ASSERT_NEVER(lbl, cond, clk, rst_n)
`endif
`endif

// ===== hdl/dahdsr_pkg.sv =====
// types, codes and constants of the envelope generator
`default_nettype none
package dahdsr_pkg;

  localparam int unsigned TICKS_W   = 24;
  localparam int unsigned ELAPSED_W = 25;
  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned COUNT_W   = 10;
  localparam int unsigned NUM_W     = LEVEL_W + TICKS_W;
  localparam int unsigned MAX_VISITS = 8;
  localparam int unsigned VISIT_W   = $clog2(MAX_VISITS);
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [LEVEL_W-1:0]   FULL_LEVEL  = '1;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd6;

  typedef enum logic [2:0] {
    STG_IDLE    = 3'd0,
    STG_DELAY   = 3'd1,
    STG_ATTACK  = 3'd2,
    STG_HOLD    = 3'd3,
    STG_DECAY   = 3'd4,
    STG_SUSTAIN = 3'd5,
    STG_RELEASE = 3'd6
  } stage_e;

  typedef enum logic [2:0] {
    FSM_WAIT,
    FSM_ROLL,
    FSM_MUL,
    FSM_DIV,
    FSM_DONE
  } fsm_e;

  // request to the shared divider
  typedef struct packed {
    logic               start;
    logic [NUM_W-1:0]   num;
    logic [TICKS_W-1:0] den;
  } div_req_t;

  // answer from the shared divider
  typedef struct packed {
    logic               busy;
    logic               done;
    logic [LEVEL_W-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== hdl/dahdsr_envelope_generator.sv =====
// top level of the delay-attack-hold-decay-sustain-release envelope generator
// Usage: each input beat on s_axis carries a gate bit and a tick count; each
// one yields exactly one output beat on m_axis with the envelope level and
// stage code after those ticks. Stage lengths, sustain level and the enable
// bit are to be written through the cfg port while no beat is in flight; the
// block itself does not enforce this.
// Operation: after a beat is taken, a small sequencer walks the stages, one
// stage visit per cycle through a single compare-and-subtract unit. A ramp
// stage then does a 16x24 multiply and runs the shared one-bit-per-cycle
// divider (16 bit steps, then the quotient is handed back), which sets the
// worst case. A disabled block or an idle envelope skips the walk, and
// s_axis_tready is low until the sequencer is back in its wait state.
// The output beat sits in its own register: the next input beat is taken
// while a result still waits, but a second result is not finished until the
// first has gone, so a stalled receiver eventually stalls the input.
// Reset: the envelope is idle at level zero, all but the payload registers
// read zero and the block is disabled; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"
module dahdsr_envelope_generator (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [dahdsr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [dahdsr_pkg::TICKS_W-1:0]  cfg_wdata_i,
  // input stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [15:0]                     s_axis_tdata,  // gate, tick_count
  // result stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [23:0]                          m_axis_tdata   // level, stage_code
);
  import dahdsr_pkg::*;

  // configuration registers
  logic               enable_q;
  logic [TICKS_W-1:0] delay_q, attack_q, hold_q, decay_q, release_q;
  logic [LEVEL_W-1:0] sustain_q;

  // envelope state
  fsm_e                 fsm_q, fsm_d;
  stage_e               stage_q, stage_d;
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic [LEVEL_W-1:0]   level_q, level_d;
  logic [LEVEL_W-1:0]   rel_q, rel_d;
  logic [VISIT_W-1:0]   visit_q, visit_d;

  // multiplier operands and divisor
  logic [LEVEL_W-1:0]   mul_a_q, mul_a_d;
  logic [TICKS_W-1:0]   mul_b_q, mul_b_d;
  logic [TICKS_W-1:0]   den_q, den_d;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic [LEVEL_W-1:0]   out_level_q, out_level_d;
  logic [2:0]           out_stage_q, out_stage_d;

  // input beat fields
  logic                 in_gate;
  logic [COUNT_W-1:0]   in_ticks;
  logic                 in_accept;

  // entry logic
  logic                 resting;
  stage_e               entry_stage;
  logic [ELAPSED_W-1:0] entry_elapsed;
  logic [ELAPSED_W:0]   entry_sum;
  logic [ELAPSED_W-1:0] entry_sat;

  // shared compare-and-subtract unit
  logic [TICKS_W-1:0]   dur;
  logic                 e_lt;
  logic [ELAPSED_W-1:0] e_sub;
  logic                 last_visit;
  logic                 out_free;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_gate   = s_axis_tdata[0];
  assign in_ticks  = s_axis_tdata[COUNT_W:1];
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = fsm_q == FSM_WAIT;
  assign out_free  = !out_valid_q || m_axis_tready;

  // gate handling and saturating tick add at the start of an item
  always_comb begin
    resting       = stage_q == STG_IDLE || stage_q == STG_RELEASE;
    entry_stage   = stage_q;
    entry_elapsed = elapsed_q;
    if (in_gate && resting) begin
      entry_stage   = STG_DELAY;
      entry_elapsed = '0;
    end else if (!in_gate && !resting) begin
      entry_stage   = STG_RELEASE;
      entry_elapsed = '0;
    end
    entry_sum = {1'b0, entry_elapsed} + {{(ELAPSED_W + 1 - COUNT_W){1'b0}}, in_ticks};
    entry_sat = entry_sum[ELAPSED_W] ? ELAPSED_MAX : entry_sum[ELAPSED_W-1:0];
  end

  // stage length selection for the shared compare and subtract
  always_comb begin
    case (stage_q)
      STG_DELAY:   dur = delay_q;
      STG_ATTACK:  dur = attack_q;
      STG_HOLD:    dur = hold_q;
      STG_DECAY:   dur = decay_q;
      STG_RELEASE: dur = release_q;
      default:     dur = '0;
    endcase
  end

  assign e_lt       = elapsed_q < {1'b0, dur};
  assign e_sub      = elapsed_q - {1'b0, dur};
  assign last_visit = visit_q == VISIT_W'(MAX_VISITS - 1);

  // sequencer next state
  always_comb begin
    fsm_d = fsm_q;
    case (fsm_q)
      FSM_WAIT: begin
        if (in_accept) begin
          fsm_d = (enable_q && entry_stage != STG_IDLE) ? FSM_ROLL : FSM_DONE;
        end
      end
      FSM_ROLL: begin
        case (stage_q)
          STG_DELAY, STG_HOLD: begin
            fsm_d = (e_lt || last_visit) ? FSM_DONE : FSM_ROLL;
          end
          STG_ATTACK, STG_DECAY: begin
            if (e_lt) begin
              fsm_d = FSM_MUL;
            end else begin
              fsm_d = last_visit ? FSM_DONE : FSM_ROLL;
            end
          end
          STG_RELEASE: fsm_d = e_lt ? FSM_MUL : FSM_DONE;
          default:     fsm_d = FSM_DONE;
        endcase
      end
      FSM_MUL: fsm_d = FSM_DIV;
      FSM_DIV: begin
        if (div_rsp.done) begin
          fsm_d = FSM_DONE;
        end
      end
      FSM_DONE: begin
        if (out_free) begin
          fsm_d = FSM_WAIT;
        end
      end
      default: fsm_d = FSM_WAIT;
    endcase
  end

  // envelope datapath
  always_comb begin
    stage_d   = stage_q;
    elapsed_d = elapsed_q;
    level_d   = level_q;
    rel_d     = rel_q;
    visit_d   = visit_q;
    mul_a_d   = mul_a_q;
    mul_b_d   = mul_b_q;
    den_d     = den_q;
    case (fsm_q)
      FSM_WAIT: begin
        if (in_accept && enable_q) begin
          stage_d   = entry_stage;
          elapsed_d = entry_sat;
          visit_d   = '0;
          if (!in_gate && !resting) begin
            rel_d = level_q;
          end
          if (entry_stage == STG_IDLE) begin
            level_d = '0;
          end
        end
      end
      FSM_ROLL: begin
        visit_d = visit_q + 1'b1;
        den_d   = dur;
        mul_b_d = elapsed_q[TICKS_W-1:0];
        case (stage_q)
          STG_DELAY: begin
            level_d = '0;
            if (!e_lt) begin
              elapsed_d = e_sub;
              stage_d   = STG_ATTACK;
            end
          end
          STG_ATTACK: begin
            mul_a_d = FULL_LEVEL;
            if (!e_lt) begin
              elapsed_d = e_sub;
              stage_d   = STG_HOLD;
            end
          end
          STG_HOLD: begin
            level_d = FULL_LEVEL;
            if (!e_lt) begin
              elapsed_d = e_sub;
              stage_d   = STG_DECAY;
            end
          end
          STG_DECAY: begin
            mul_a_d = FULL_LEVEL - sustain_q;
            if (!e_lt) begin
              elapsed_d = e_sub;
              stage_d   = STG_SUSTAIN;
            end
          end
          STG_SUSTAIN: level_d = sustain_q;
          STG_RELEASE: begin
            mul_a_d = rel_q;
            mul_b_d = dur - elapsed_q[TICKS_W-1:0];
            if (!e_lt) begin
              level_d = '0;
              stage_d = STG_IDLE;
            end
          end
          default: begin
            level_d = '0;
            stage_d = STG_IDLE;
          end
        endcase
      end
      FSM_DIV: begin
        if (div_rsp.done) begin
          level_d = (stage_q == STG_DECAY) ? FULL_LEVEL - div_rsp.quot : div_rsp.quot;
        end
      end
      default: ;
    endcase
  end

  // divider request: product of the registered operands
  always_comb begin
    div_req.start = fsm_q == FSM_MUL;
    div_req.num   = NUM_W'(mul_a_q) * NUM_W'(mul_b_q);
    div_req.den   = den_q;
  end

  dahdsr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    out_level_d = out_level_q;
    out_stage_d = out_stage_q;
    if (fsm_q == FSM_DONE && out_free) begin
      out_valid_d = 1'b1;
      out_level_d = level_q;
      out_stage_d = stage_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_stage_q, out_level_q};

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      delay_q   <= '0;
      attack_q  <= '0;
      hold_q    <= '0;
      decay_q   <= '0;
      sustain_q <= '0;
      release_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENABLE:  enable_q  <= cfg_wdata_i[0];
        CFG_DELAY:   delay_q   <= cfg_wdata_i;
        CFG_ATTACK:  attack_q  <= cfg_wdata_i;
        CFG_HOLD:    hold_q    <= cfg_wdata_i;
        CFG_DECAY:   decay_q   <= cfg_wdata_i;
        CFG_SUSTAIN: sustain_q <= cfg_wdata_i[LEVEL_W-1:0];
        CFG_RELEASE: release_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // control and envelope state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= FSM_WAIT;
      stage_q     <= STG_IDLE;
      elapsed_q   <= '0;
      level_q     <= '0;
      rel_q       <= '0;
      visit_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      stage_q     <= stage_d;
      elapsed_q   <= elapsed_d;
      level_q     <= level_d;
      rel_q       <= rel_d;
      visit_q     <= visit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mul_a_q     <= mul_a_d;
    mul_b_q     <= mul_b_d;
    den_q       <= den_d;
    out_level_q <= out_level_d;
    out_stage_q <= out_stage_d;
  end

  `ASSERT_CLK(a_idle_is_silent, stage_q == STG_IDLE |-> level_q == '0, clk_i, rst_ni)
  `ASSERT_CLK(a_busy_after_accept, in_accept |=> !s_axis_tready, clk_i, rst_ni)
  `ASSERT_CLK(a_div_only_in_div, div_rsp.done |-> fsm_q == FSM_DIV, clk_i, rst_ni)

endmodule
`default_nettype wire

// ===== hdl/dahdsr_div.sv =====
// radix-2 restoring divider, 16 quotient bits, one bit per cycle
`default_nettype none
`include "assert_macros.svh"
module dahdsr_div (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  dahdsr_pkg::div_req_t      req_i,
  output dahdsr_pkg::div_rsp_t      rsp_o
);
  import dahdsr_pkg::*;

  localparam int unsigned STEP_W = $clog2(LEVEL_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(LEVEL_W - 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic [TICKS_W-1:0]   rem_q, rem_d;
  logic [LEVEL_W-1:0]   quo_q, quo_d;
  logic [TICKS_W-1:0]   den_q, den_d;
  logic [TICKS_W:0]     trial;
  logic [TICKS_W:0]     diff;
  logic                 fits;

  // one trial subtraction per cycle; the quotient shifts in where the
  // low numerator bits shift out
  assign trial = {rem_q, quo_q[LEVEL_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  // next state of the divider
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (req_i.start) begin
      // quotient stays below 2^16, so the top bits start below the divisor
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = req_i.num[NUM_W-1:LEVEL_W];
      quo_d  = req_i.num[LEVEL_W-1:0];
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d  = fits ? diff[TICKS_W-1:0] : trial[TICKS_W-1:0];
      quo_d  = {quo_q[LEVEL_W-2:0], fits};
      step_d = step_q + 1'b1;
      if (step_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

  `ASSERT_NEVER(a_start_while_busy, req_i.start && busy_q, clk_i, rst_ni)
  `ASSERT_CLK(a_last_step_done, busy_q && step_q == LAST_STEP |=> done_q, clk_i, rst_ni)
  `ASSERT_CLK(a_done_after_busy, done_q |-> $past(busy_q) && !busy_q, clk_i, rst_ni)

endmodule
`default_nettype wire
